>>> rtl/crre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crre_pkg
// Shared types, constants and helpers for the conv2d row engine.
// ----------------------------------------------------------------------------
package crre_pkg;

    localparam int DATA_BITS        = 16;
    localparam int FRAC_BITS        = 12;
    localparam int OUT_BITS         = DATA_BITS - 1;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_SIDE_DEF     = 64;
    localparam int MAX_FILTERS_DEF  = 32;
    localparam int MAX_KERNEL_DEF   = 5;
    localparam int MAX_STEP         = 4;
    localparam int MAX_PAD          = 4;
    localparam int ROW_LIMIT        = 64;
    localparam int CFG_DATA_BITS    = 7;

    typedef enum logic [1:0] {
        KIND_WEIGHT = 2'd0,
        KIND_BIAS   = 2'd1,
        KIND_PIXEL  = 2'd2,
        KIND_ROW    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CFG_CHANNELS = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_WIDTH    = 3'd2,
        CFG_FILTERS  = 3'd3,
        CFG_KROWS    = 3'd4,
        CFG_KCOLS    = 3'd5,
        CFG_STEP     = 3'd6,
        CFG_PAD      = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic load;
        logic capture;
        logic check;
        logic setup1;
        logic setup2;
        logic setup3;
        logic col_start;
        logic tap;
        logic sum_load;
        logic emit;
        logic emit_err;
    } t_cmd;

    typedef struct packed {
        logic ok;
        logic last_tap;
        logic last_col;
        logic out_free;
    } t_stat;

    function automatic int addr_bits(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // quotient of x by s for s in 1..4; x stays below 256
    function automatic logic [7:0] div_step(input logic [7:0] x, input logic [2:0] s);
        logic [16:0] m;
        logic [7:0]  q;
        m = 17'(x) * 17'd171;
        case (s)
            3'd1:    q = x;
            3'd2:    q = x >> 1;
            3'd3:    q = m[16:9];
            3'd4:    q = x >> 2;
            default: q = '0;
        endcase
        return q;
    endfunction

endpackage

>>> rtl/crre_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crre_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module crre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [crre_pkg::addr_bits(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [crre_pkg::addr_bits(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    import crre_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> rtl/crre_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crre_ctrl
// Sequencer for loads, row query checks, setup, tap loop and result words.
// ----------------------------------------------------------------------------
module crre_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [1:0]      i_kind,
    input  crre_pkg::t_stat i_stat,
    output crre_pkg::t_cmd  o_cmd
);
    import crre_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHECK = 11'b000_0000_0010,
        S_SET1  = 11'b000_0000_0100,
        S_SET2  = 11'b000_0000_1000,
        S_SET3  = 11'b000_0001_0000,
        S_COL   = 11'b000_0010_0000,
        S_TAP   = 11'b000_0100_0000,
        S_DRAIN = 11'b000_1000_0000,
        S_FINAL = 11'b001_0000_0000,
        S_EMIT  = 11'b010_0000_0000,
        S_ERR   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_drain, n_drain;
    logic   accept;

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        n_drain = r_drain;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == KIND_ROW) begin
                        o_cmd.capture = 1'b1;
                        n_state       = S_CHECK;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = S_SET1;
            end
            S_SET1: begin
                if (i_stat.ok) begin
                    o_cmd.setup1 = 1'b1;
                    n_state      = S_SET2;
                end else begin
                    n_state = S_ERR;
                end
            end
            S_SET2: begin
                o_cmd.setup2 = 1'b1;
                n_state      = S_SET3;
            end
            S_SET3: begin
                o_cmd.setup3 = 1'b1;
                n_state      = S_COL;
            end
            S_COL: begin
                o_cmd.col_start = 1'b1;
                n_state         = S_TAP;
            end
            S_TAP: begin
                o_cmd.tap = 1'b1;
                if (i_stat.last_tap) begin
                    n_drain = 1'b0;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                o_cmd.sum_load = 1'b1;
                n_state        = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_stat.last_col ? S_IDLE : S_COL;
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_err = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_drain <= n_drain;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.emit || o_cmd.emit_err) |-> i_stat.out_free)
        else $error("result word loaded over a pending word");

    a_final_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINAL) |-> $past(r_state == S_DRAIN))
        else $error("sum taken before pipeline drained");

    a_tap_loop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAP && !i_stat.last_tap) |=> (r_state == S_TAP))
        else $error("tap loop left early");

endmodule

>>> rtl/crre_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crre_dp
// Datapath: config registers, stores, address walk, MAC and output word.
// ----------------------------------------------------------------------------
module crre_dp #(
    parameter int MAX_CHANNELS = crre_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SIDE     = crre_pkg::MAX_SIDE_DEF,
    parameter int MAX_FILTERS  = crre_pkg::MAX_FILTERS_DEF,
    parameter int MAX_KERNEL   = crre_pkg::MAX_KERNEL_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [2:0]                          i_cfg_index,
    input  logic [crre_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    input  logic [1:0]                          i_kind,
    input  logic [15:0]                         i_address,
    input  logic signed [crre_pkg::DATA_BITS-1:0] i_load_value,
    input  logic [4:0]                          i_filter_index,
    input  logic [6:0]                          i_row_index,
    input  crre_pkg::t_cmd                      i_cmd,
    output crre_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [crre_pkg::OUT_BITS-1:0]       o_out_value,
    output logic [5:0]                          o_out_column,
    output logic                                o_status,
    output logic                                o_last
);
    import crre_pkg::*;

    localparam int W_DEPTH = MAX_FILTERS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int I_DEPTH = MAX_CHANNELS * MAX_SIDE * MAX_SIDE;
    localparam int WAW     = addr_bits(W_DEPTH);
    localparam int BAW     = addr_bits(MAX_FILTERS);
    localparam int IAW     = addr_bits(I_DEPTH);
    localparam int CBW     = IAW + 1;
    localparam int PSW     = ((IAW > 18) ? IAW : 18) + 3;
    localparam int PROD_W  = 2 * DATA_BITS;
    localparam int ACC_W   = PROD_W + $clog2(MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL) + 1;
    localparam int SUM_W   = ACC_W + 1;
    localparam logic [OUT_BITS-1:0] SAT_MAX = '1;

    // config
    logic [4:0] r_chan;
    logic [6:0] r_h, r_w;
    logic [5:0] r_fcnt;
    logic [2:0] r_kr, r_kc, r_step, r_pad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan <= 5'd1;
            r_h    <= 7'd28;
            r_w    <= 7'd28;
            r_fcnt <= 6'd8;
            r_kr   <= 3'd3;
            r_kc   <= 3'd3;
            r_step <= 3'd1;
            r_pad  <= 3'd0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CHANNELS: r_chan <= i_cfg_data[4:0];
                CFG_HEIGHT:   r_h    <= i_cfg_data[6:0];
                CFG_WIDTH:    r_w    <= i_cfg_data[6:0];
                CFG_FILTERS:  r_fcnt <= i_cfg_data[5:0];
                CFG_KROWS:    r_kr   <= i_cfg_data[2:0];
                CFG_KCOLS:    r_kc   <= i_cfg_data[2:0];
                CFG_STEP:     r_step <= i_cfg_data[2:0];
                CFG_PAD:      r_pad  <= i_cfg_data[2:0];
                default:      r_pad  <= r_pad;
            endcase
        end
    end

    // stores
    logic                 w_we, b_we, p_we;
    logic [DATA_BITS-1:0] w_rd, b_rd, p_rd;
    logic [WAW-1:0]       r_wa;
    logic signed [PSW-1:0] pa;
    logic [4:0]           r_f;
    logic [6:0]           r_row;

    assign w_we = i_cmd.load && (i_kind == KIND_WEIGHT) && (int'(i_address) < W_DEPTH);
    assign b_we = i_cmd.load && (i_kind == KIND_BIAS)   && (int'(i_address) < MAX_FILTERS);
    assign p_we = i_cmd.load && (i_kind == KIND_PIXEL)  && (int'(i_address) < I_DEPTH);

    crre_ram #(.WIDTH(DATA_BITS), .DEPTH(W_DEPTH)) u_wram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (WAW'(i_address)),
        .i_wdata (i_load_value),
        .i_re    (i_cmd.tap),
        .i_raddr (r_wa),
        .o_rdata (w_rd)
    );

    crre_ram #(.WIDTH(DATA_BITS), .DEPTH(MAX_FILTERS)) u_bram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (BAW'(i_address)),
        .i_wdata (i_load_value),
        .i_re    (i_cmd.col_start),
        .i_raddr (BAW'(r_f)),
        .o_rdata (b_rd)
    );

    crre_ram #(.WIDTH(DATA_BITS), .DEPTH(I_DEPTH)) u_pram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (IAW'(i_address)),
        .i_wdata (i_load_value),
        .i_re    (i_cmd.tap),
        .i_raddr (pa[IAW-1:0]),
        .o_rdata (p_rd)
    );

    // query check
    logic [7:0] hp, wp, ho, wo;
    logic       cfg_ok, q_ok;
    logic       r_ok;
    logic [5:0] r_wo_m1;

    always_comb begin
        hp = 8'(r_h) + 8'({r_pad, 1'b0});
        wp = 8'(r_w) + 8'({r_pad, 1'b0});
        ho = div_step(hp - 8'(r_kr), r_step) + 8'd1;
        wo = div_step(wp - 8'(r_kc), r_step) + 8'd1;
        cfg_ok = (r_chan != '0) && (int'(r_chan) <= MAX_CHANNELS)
              && (r_h != '0) && (int'(r_h) <= MAX_SIDE)
              && (r_w != '0) && (int'(r_w) <= MAX_SIDE)
              && (r_fcnt != '0) && (int'(r_fcnt) <= MAX_FILTERS)
              && (r_kr != '0) && (int'(r_kr) <= MAX_KERNEL)
              && (r_kc != '0) && (int'(r_kc) <= MAX_KERNEL)
              && (r_step != '0) && (int'(r_step) <= MAX_STEP)
              && (int'(r_pad) <= MAX_PAD);
        q_ok = cfg_ok && (hp >= 8'(r_kr)) && (wp >= 8'(r_kc))
            && (int'(wo) <= ROW_LIMIT) && (6'(r_f) < r_fcnt) && (8'(r_row) < ho);
    end

    // setup
    logic [9:0]          r_fc;
    logic [12:0]         r_fck;
    logic [15:0]         r_wbase;
    logic [13:0]         r_hw;
    logic signed [10:0]  r_iy0, r_iy;
    logic signed [18:0]  r_row0w, r_row_off;
    logic signed [9:0]   r_col0;
    logic [5:0]          r_ox;
    logic [CBW-1:0]      r_chan_base;
    logic [4:0]          r_c;
    logic [2:0]          r_kh, r_kw;

    // tap walk
    logic signed [9:0] ix;
    logic              tap_ok, kw_end, kh_end, c_end;

    always_comb begin
        ix     = r_col0 + $signed({7'b0, r_kw});
        tap_ok = (r_iy >= 0) && (r_iy < $signed({4'b0, r_h}))
              && (ix >= 0) && (ix < $signed({3'b0, r_w}));
        pa     = $signed(PSW'(r_chan_base)) + PSW'(r_row_off) + PSW'(ix);
        kw_end = (r_kw == r_kc - 3'd1);
        kh_end = (r_kh == r_kr - 3'd1);
        c_end  = (r_c == r_chan - 5'd1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_f   <= i_filter_index;
            r_row <= i_row_index;
        end
        if (i_cmd.check) begin
            r_ok    <= q_ok;
            r_wo_m1 <= 6'(wo - 8'd1);
        end
        if (i_cmd.setup1) begin
            r_fc   <= 10'(r_f) * 10'(r_chan);
            r_hw   <= 14'(r_h) * 14'(r_w);
            r_iy0  <= $signed({1'b0, 10'(r_row) * 10'(r_step)}) - $signed(11'(r_pad));
            r_col0 <= -$signed(10'(r_pad));
            r_ox   <= '0;
        end
        if (i_cmd.setup2) begin
            r_fck   <= 13'(r_fc) * 13'(r_kr);
            r_row0w <= 19'(r_iy0) * $signed({12'b0, r_w});
        end
        if (i_cmd.setup3) begin
            r_wbase <= 16'(r_fck) * 16'(r_kc);
        end
        if (i_cmd.col_start) begin
            r_c         <= '0;
            r_kh        <= '0;
            r_kw        <= '0;
            r_wa        <= WAW'(r_wbase);
            r_chan_base <= '0;
            r_row_off   <= r_row0w;
            r_iy        <= r_iy0;
        end else if (i_cmd.tap) begin
            r_wa <= r_wa + 1'b1;
            if (kw_end) begin
                r_kw <= '0;
                if (kh_end) begin
                    r_kh        <= '0;
                    r_c         <= r_c + 5'd1;
                    r_chan_base <= r_chan_base + CBW'(r_hw);
                    r_row_off   <= r_row0w;
                    r_iy        <= r_iy0;
                end else begin
                    r_kh      <= r_kh + 3'd1;
                    r_row_off <= r_row_off + $signed({12'b0, r_w});
                    r_iy      <= r_iy + 11'sd1;
                end
            end else begin
                r_kw <= r_kw + 3'd1;
            end
        end
        if (i_cmd.emit) begin
            r_ox   <= r_ox + 6'd1;
            r_col0 <= r_col0 + $signed({7'b0, r_step});
        end
    end

    // MAC pipeline
    logic                     r_v1, r_v2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  r_sum;
    logic [OUT_BITS-1:0]      res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.tap && tap_ok;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_rd) * $signed(p_rd);
        if (i_cmd.col_start) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.sum_load) begin
            r_sum <= SUM_W'(r_acc) + SUM_W'($signed({b_rd, 12'h800}));
        end
    end

    always_comb begin
        priority if (r_sum[SUM_W-1]) begin
            res = '0;
        end else if (|r_sum[SUM_W-2:FRAC_BITS+OUT_BITS]) begin
            res = SAT_MAX;
        end else begin
            res = r_sum[FRAC_BITS+OUT_BITS-1:FRAC_BITS];
        end
    end

    // output word
    logic r_out_valid;

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit || i_cmd.emit_err) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_out_value  <= res;
            o_out_column <= r_ox;
            o_status     <= 1'b0;
            o_last       <= (r_ox == r_wo_m1);
        end else if (i_cmd.emit_err) begin
            o_out_value  <= '0;
            o_out_column <= '0;
            o_status     <= 1'b1;
            o_last       <= 1'b1;
        end
    end

    assign o_stat.ok       = r_ok;
    assign o_stat.last_tap = kw_end && kh_end && c_end;
    assign o_stat.last_col = (r_ox == r_wo_m1);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    a_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.col_start |-> (!r_v1 && !r_v2))
        else $error("column started with taps in flight");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_status) |-> o_last)
        else $error("error word without last");

    a_emit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_ok)
        else $error("result emitted for a rejected query");

endmodule

>>> rtl/conv2d_relu_row_engine.sv
`timescale 1ns / 1ps
// Flow: a load word is taken while idle and does not stall the input. A row query runs the check
// and setup states, then for each output column a tap loop over C*KR*KC taps, a drain and an emit.
// The single shared multiply-accumulate takes one tap per cycle; the input stalls until the row is done.
// An invalid query goes from the check to an error word with status and last set.
// Reset is synchronous, active low; config returns to defaults, stores keep contents.
// ----------------------------------------------------------------------------
// conv2d_relu_row_engine
// Multi-channel 2D convolution with bias and ReLU, one output row per query.
// ----------------------------------------------------------------------------
module conv2d_relu_row_engine #(
    parameter int MAX_CHANNELS = crre_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_SIDE     = crre_pkg::MAX_SIDE_DEF,
    parameter int MAX_FILTERS  = crre_pkg::MAX_FILTERS_DEF,
    parameter int MAX_KERNEL   = crre_pkg::MAX_KERNEL_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [2:0]                            i_cfg_index,
    input  logic [crre_pkg::CFG_DATA_BITS-1:0]    i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_kind,
    input  logic [15:0]                           i_address,
    input  logic signed [crre_pkg::DATA_BITS-1:0] i_load_value,
    input  logic [4:0]                            i_filter_index,
    input  logic [6:0]                            i_row_index,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [crre_pkg::OUT_BITS-1:0]         o_out_value,
    output logic [5:0]                            o_out_column,
    output logic                                  o_status,
    output logic                                  o_last
);
    import crre_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    crre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_kind     (i_kind),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    crre_dp #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .MAX_SIDE     (MAX_SIDE),
        .MAX_FILTERS  (MAX_FILTERS),
        .MAX_KERNEL   (MAX_KERNEL)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_kind         (i_kind),
        .i_address      (i_address),
        .i_load_value   (i_load_value),
        .i_filter_index (i_filter_index),
        .i_row_index    (i_row_index),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_value    (o_out_value),
        .o_out_column   (o_out_column),
        .o_status       (o_status),
        .o_last         (o_last)
    );

endmodule

>>> dv/conv2d_relu_row_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_relu_row_engine_tb
// Loads weight, bias and pixel words into the engine across several
// geometries, including the extreme and invalid ones, asks for output rows,
// and checks every emitted word against a local conv + bias + ReLU predictor.
// ----------------------------------------------------------------------------
module conv2d_relu_row_engine_tb;
    import crre_pkg::*;

    localparam int WEIGHT_DEPTH = MAX_FILTERS_DEF * MAX_CHANNELS_DEF
                                  * MAX_KERNEL_DEF * MAX_KERNEL_DEF;
    localparam int BIAS_DEPTH   = MAX_FILTERS_DEF;
    localparam int IMAGE_DEPTH  = MAX_CHANNELS_DEF * MAX_SIDE_DEF * MAX_SIDE_DEF;
    localparam int REG_W [8]    = '{5, 7, 7, 6, 3, 3, 3, 3};

    typedef struct {
        logic [OUT_BITS-1:0] value;
        logic [5:0]          column;
        logic                status;
        logic                last;
    } row_word_t;

    typedef struct {
        t_kind       kind;
        logic [15:0] addr;
        logic [15:0] value;
        logic [4:0]  filter;
        logic [6:0]  row;
        bit          is_err;
    } stim_row_t;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [2:0]                  i_cfg_index;
    logic [CFG_DATA_BITS-1:0]    i_cfg_data;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [1:0]                  i_kind;
    logic [15:0]                 i_address;
    logic signed [DATA_BITS-1:0] i_load_value;
    logic [4:0]                  i_filter_index;
    logic [6:0]                  i_row_index;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [OUT_BITS-1:0]         o_out_value;
    logic [5:0]                  o_out_column;
    logic                        o_status;
    logic                        o_last;

    logic signed [15:0] weight_mem [WEIGHT_DEPTH];
    logic signed [15:0] bias_mem   [BIAS_DEPTH];
    logic signed [15:0] image_mem  [IMAGE_DEPTH];
    bit                 weight_seen [WEIGHT_DEPTH];
    bit                 bias_seen   [BIAS_DEPTH];
    bit                 image_seen  [IMAGE_DEPTH];

    int unsigned geo [8];
    row_word_t   expected_words [$];
    int          mismatches;
    bit          calm;

    conv2d_relu_row_engine DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // out-of-range geometry gives ho = 0
    function automatic void out_dims(output int ho, output int wo);
        int c, h, w, f, kr, kc, s, p;
        c = geo[0]; h = geo[1]; w = geo[2]; f = geo[3];
        kr = geo[4]; kc = geo[5]; s = geo[6]; p = geo[7];
        ho = 0;
        wo = 0;
        if (c < 1 || c > MAX_CHANNELS_DEF || h < 1 || h > MAX_SIDE_DEF || w < 1
            || w > MAX_SIDE_DEF || f < 1 || f > MAX_FILTERS_DEF || kr < 1
            || kr > MAX_KERNEL_DEF || kc < 1 || kc > MAX_KERNEL_DEF || s < 1
            || s > MAX_STEP || p > MAX_PAD) return;
        if (h + 2 * p < kr || w + 2 * p < kc) return;
        wo = (w + 2 * p - kc) / s + 1;
        if (wo > ROW_LIMIT) return;
        ho = (h + 2 * p - kr) / s + 1;
    endfunction

    function automatic void push_error_word();
        row_word_t e;
        e.value = '0; e.column = '0; e.status = 1'b1; e.last = 1'b1;
        expected_words.push_back(e);
    endfunction

    function automatic void predict_row(int fi, int ri);
        int ho, wo, ch, kh, kw, iy, ix, wa, pa;
        longint acc, res;
        row_word_t e;
        out_dims(ho, wo);
        if (ho == 0 || fi >= int'(geo[3]) || ri >= ho) begin
            push_error_word();
            return;
        end
        for (int ox = 0; ox < wo; ox++) begin
            acc = longint'(bias_mem[fi]) * 4096;
            for (ch = 0; ch < int'(geo[0]); ch++)
                for (kh = 0; kh < int'(geo[4]); kh++) begin
                    iy = ri * int'(geo[6]) + kh - int'(geo[7]);
                    if (iy < 0 || iy >= int'(geo[1])) continue;
                    for (kw = 0; kw < int'(geo[5]); kw++) begin
                        ix = ox * int'(geo[6]) + kw - int'(geo[7]);
                        if (ix < 0 || ix >= int'(geo[2])) continue;
                        wa = ((fi * geo[0] + ch) * geo[4] + kh) * geo[5] + kw;
                        pa = (ch * geo[1] + iy) * geo[2] + ix;
                        acc += longint'(weight_mem[wa]) * longint'(image_mem[pa]);
                    end
                end
            res = 0;
            if (acc > 0) begin
                res = (acc + 2048) >>> 12;
                if (res > 32767) res = 32767;
            end
            e.value = OUT_BITS'(res);
            e.column = 6'(ox);
            e.status = 1'b0;
            e.last = (ox + 1 == wo);
            expected_words.push_back(e);
        end
    endfunction

    function automatic void apply_word(t_kind k, logic [15:0] a, logic [15:0] v,
                                       logic [4:0] f, logic [6:0] r);
        case (k)
            KIND_WEIGHT: if (a < WEIGHT_DEPTH) begin
                weight_mem[a] = v; weight_seen[a] = 1'b1;
            end
            KIND_BIAS: if (a < BIAS_DEPTH) begin
                bias_mem[a] = v; bias_seen[a] = 1'b1;
            end
            KIND_PIXEL: begin
                image_mem[a] = v; image_seen[a] = 1'b1;
            end
            default: predict_row(f, r);
        endcase
    endfunction

    function automatic logic [15:0] rand_q();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($urandom_range(8192)) - 16'd4096;
    endfunction

    task automatic send_word(t_kind k, logic [15:0] a, logic [15:0] v,
                             logic [4:0] f, logic [6:0] r);
        while (!calm && $urandom_range(99) < 33) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_kind         <= k;
        i_address      <= a;
        i_load_value   <= v;
        i_filter_index <= f;
        i_row_index    <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drive_and_track(t_kind k, logic [15:0] a, logic [15:0] v,
                                   logic [4:0] f, logic [6:0] r);
        send_word(k, a, v, f, r);
        apply_word(k, a, v, f, r);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_geometry(input int unsigned g [8]);
        drain();
        for (int i = 0; i < 8; i++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= t_cfg_idx'(i);
            i_cfg_data  <= CFG_DATA_BITS'(g[i]);
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            geo[i] = g[i] & ((1 << REG_W[i]) - 1);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // fill every store entry this geometry can read that is still unwritten
    task automatic prime_stores();
        int nw, ni;
        nw = geo[3] * geo[0] * geo[4] * geo[5];
        ni = geo[0] * geo[1] * geo[2];
        for (int a = 0; a < nw; a++)
            if (!weight_seen[a]) drive_and_track(KIND_WEIGHT, 16'(a), rand_q(), '0, '0);
        for (int a = 0; a < int'(geo[3]); a++)
            if (!bias_seen[a]) drive_and_track(KIND_BIAS, 16'(a), rand_q(), '0, '0);
        for (int a = 0; a < ni; a++)
            if (!image_seen[a]) drive_and_track(KIND_PIXEL, 16'(a), rand_q(), '0, '0);
    endtask

    task automatic random_words(int count, int calm_count);
        int ho, wo, sel, span;
        t_kind k;
        logic [15:0] a;
        out_dims(ho, wo);
        for (int n = 0; n < count; n++) begin
            calm = (n < calm_count);
            sel = $urandom_range(99);
            if (sel < 5 || (ho == 0 && sel < 40)) begin
                drive_and_track(KIND_ROW, 16'($urandom), 16'($urandom),
                                5'($urandom), 7'($urandom));
            end else if (sel < 40) begin
                drive_and_track(KIND_ROW, 16'($urandom), 16'($urandom),
                                5'($urandom_range(geo[3] - 1)),
                                7'($urandom_range(ho - 1)));
            end else begin
                k = t_kind'($urandom_range(2));
                case (k)
                    KIND_WEIGHT: span = geo[3] * geo[0] * geo[4] * geo[5];
                    KIND_BIAS:   span = geo[3];
                    default:     span = geo[0] * geo[1] * geo[2];
                endcase
                if (ho == 0 || $urandom_range(9) < 3) a = 16'($urandom);
                else a = 16'($urandom_range(span - 1));
                drive_and_track(k, a, rand_q(), 5'($urandom), 7'($urandom));
            end
        end
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin
        row_word_t e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected output word: value %0d column %0d status %0d last %0d",
                       o_out_value, o_out_column, o_status, o_last);
                mismatches++;
            end else begin
                e = expected_words.pop_front();
                if (o_out_value !== e.value) begin
                    $error("out_value expected %0d actual %0d", e.value, o_out_value);
                    mismatches++;
                end
                if (o_out_column !== e.column) begin
                    $error("out_column expected %0d actual %0d", e.column, o_out_column);
                    mismatches++;
                end
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status);
                    mismatches++;
                end
                if (o_last !== e.last) begin
                    $error("last expected %0d actual %0d", e.last, o_last);
                    mismatches++;
                end
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 33);
    end

    stim_row_t directed [14] = '{
        '{KIND_WEIGHT, 16'd12799, 16'h7FFF, 5'd0,  7'd0,   1'b0},
        '{KIND_WEIGHT, 16'hFFFF,  16'h8000, 5'd0,  7'd0,   1'b0},
        '{KIND_BIAS,   16'd32,    16'h0001, 5'd0,  7'd0,   1'b0},
        '{KIND_BIAS,   16'd0,     16'h7FFF, 5'd0,  7'd0,   1'b0},
        '{KIND_PIXEL,  16'd0,     16'h7FFF, 5'd0,  7'd0,   1'b0},
        '{KIND_WEIGHT, 16'd0,     16'h7FFF, 5'd0,  7'd0,   1'b0},
        '{KIND_ROW,    16'hFFFF,  16'hFFFF, 5'd0,  7'd0,   1'b0},
        '{KIND_BIAS,   16'd1,     16'h8000, 5'd0,  7'd0,   1'b0},
        '{KIND_ROW,    16'd0,     16'd0,    5'd1,  7'd25,  1'b0},
        '{KIND_ROW,    16'd0,     16'd0,    5'd8,  7'd0,   1'b1},
        '{KIND_ROW,    16'd0,     16'd0,    5'd31, 7'd127, 1'b1},
        '{KIND_ROW,    16'd0,     16'd0,    5'd0,  7'd26,  1'b1},
        '{KIND_PIXEL,  16'hFFFF,  16'hFFFF, 5'd0,  7'd0,   1'b0},
        '{KIND_ROW,    16'd0,     16'd0,    5'd7,  7'd12,  1'b0}
    };

    initial begin
        i_rst_n        <= 1'b0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= CFG_CHANNELS;
        i_cfg_data     <= '0;
        i_in_valid     <= 1'b0;
        i_kind         <= KIND_WEIGHT;
        i_address      <= '0;
        i_load_value   <= '0;
        i_filter_index <= '0;
        i_row_index    <= '0;
        i_out_stall    <= 1'b0;
        mismatches = 0;
        calm = 1'b0;
        geo = '{1, 28, 28, 8, 3, 3, 1, 0};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        prime_stores();
        foreach (directed[i]) begin
            send_word(directed[i].kind, directed[i].addr, directed[i].value,
                      directed[i].filter, directed[i].row);
            if (directed[i].is_err) push_error_word();
            else apply_word(directed[i].kind, directed[i].addr, directed[i].value,
                            directed[i].filter, directed[i].row);
        end
        random_words(110, 0);

        set_geometry('{16, 8, 8, 32, 5, 5, 1, 4});
        prime_stores();
        random_words(40, 0);

        set_geometry('{1, 64, 64, 1, 1, 1, 1, 0});
        prime_stores();
        random_words(110, 50);

        set_geometry('{3, 13, 11, 3, 2, 4, 3, 2});
        prime_stores();
        random_words(100, 0);

        set_geometry('{2, 20, 17, 5, 5, 1, 4, 1});
        prime_stores();
        random_words(60, 0);

        set_geometry('{127, 28, 28, 8, 3, 3, 1, 0});
        random_words(8, 0);
        set_geometry('{1, 2, 2, 8, 5, 5, 1, 0});
        random_words(8, 0);
        set_geometry('{1, 28, 64, 8, 1, 1, 1, 4});
        random_words(8, 0);
        set_geometry('{1, 0, 28, 0, 0, 3, 0, 7});
        random_words(8, 0);
        set_geometry('{1, 28, 28, 8, 3, 6, 5, 0});
        random_words(8, 0);

        drain();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
